@@ rtl/ple_pkg.sv @@
// Shared constants, codes and types of the positional list engine.
package ple_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ACT_W  = 3;
    localparam int POS_W  = 7;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [ACT_W-1:0] ACT_APPEND   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_READ     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CONTAINS = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR    = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_POS  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_REDUCE
    } fsm_state_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_NOP,
        CELL_APPEND,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_READ,
        CELL_MATCH
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic [CMP_W-1:0]         pos;
        logic [CMP_W-1:0]         cnt;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

@@ rtl/positional_list_engine_top.sv @@
// Top level of the positional list engine: sequencer plus row of list cells.
//
// The engine holds an ordered list of up to DEPTH (64) signed 32-bit entries in a row
// of cells, one entry per cell. Each input word names one action (append, insert,
// read, remove, contains, clear) and produces exactly one result word with status,
// read value, found flag, count after the action and an empty flag. An item goes through
// these steps in order: the word is captured, then every cell shifts, loads or compares in
// parallel, then, once the output register is free, the OR trees across the row gather
// the read data and match flags into the output register. The next word is taken once
// the previous result sits in the output register, even if it is still stalled, so the
// engine takes no new word while an earlier one is still being handled. Entries are not
// cleared at reset; the count is.
module positional_list_engine_top
    import ple_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ACT_W-1:0]         action,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     found,
    output logic [POS_W-1:0]         count,
    output logic                     empty_res
);

    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] row_value;
    logic                     row_hit;

    ple_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .position   (position),
        .value      (value),
        .cmd        (cmd),
        .row_value  (row_value),
        .row_hit    (row_hit),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .read_value (read_value),
        .found      (found),
        .count      (count),
        .empty_res  (empty_res)
    );

    ple_row u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .row_value (row_value),
        .row_hit   (row_hit)
    );

endmodule

@@ rtl/ple_cell.sv @@
// One list cell: holds one entry and trades it with its neighbors on shifts.
module ple_cell
    import ple_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [IDX_W-1:0]         cell_idx,
    input  cell_cmd_t                cmd,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0] data,
    output logic                     hit,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     hit_reg;
    logic                     hit_next;
    logic signed [DATA_W-1:0] rdata_reg;
    logic signed [DATA_W-1:0] rdata_next;
    logic [CMP_W-1:0]         idx_ext;

    assign idx_ext = CMP_W'(cell_idx);

    always_comb
    begin
        data_next  = data_reg;
        hit_next   = hit_reg;
        rdata_next = rdata_reg;
        if (cmd.op != CELL_HOLD)
        begin
            hit_next   = 1'b0;
            rdata_next = '0;
        end
        unique case (cmd.op)
            CELL_APPEND:
            begin
                if (idx_ext == cmd.cnt)
                begin
                    data_next = cmd.value;
                end
            end
            CELL_INSERT:
            begin
                // Cells above the slot take the entry of their lower neighbor.
                if (idx_ext > cmd.pos)
                begin
                    data_next = left_data;
                end
                else if (idx_ext == cmd.pos)
                begin
                    data_next = cmd.value;
                end
            end
            CELL_REMOVE:
            begin
                if (idx_ext >= cmd.pos)
                begin
                    data_next = right_data;
                end
            end
            CELL_READ:
            begin
                if (idx_ext == cmd.pos)
                begin
                    hit_next   = 1'b1;
                    rdata_next = data_reg;
                end
            end
            CELL_MATCH:
            begin
                if ((idx_ext < cmd.cnt) && (data_reg == cmd.value))
                begin
                    hit_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        rdata_reg <= rdata_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign data  = data_reg;
    assign hit   = hit_reg;
    assign rdata = rdata_reg;

endmodule

@@ rtl/ple_row.sv @@
// Row of list cells with the OR trees that gather read data and match flags.
module ple_row
    import ple_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_cmd_t                cmd,
    output logic signed [DATA_W-1:0] row_value,
    output logic                     row_hit
);

    logic signed [DATA_W-1:0] cell_data  [DEPTH];
    logic signed [DATA_W-1:0] cell_rdata [DEPTH];
    logic [DEPTH-1:0]         cell_hit;
    logic [DEPTH-1:0]         bit_col    [DATA_W];

    genvar gi;
    genvar gb;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_in;
            logic signed [DATA_W-1:0] right_in;

            // Row ends loop back their own entry; only the last cell uses it.
            if (gi == 0)
            begin : g_first
                assign left_in = cell_data[gi];
            end
            else
            begin : g_mid_l
                assign left_in = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_in = cell_data[gi];
            end
            else
            begin : g_mid_r
                assign right_in = cell_data[gi+1];
            end

            ple_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_idx   (IDX_W'(gi)),
                .cmd        (cmd),
                .left_data  (left_in),
                .right_data (right_in),
                .data       (cell_data[gi]),
                .hit        (cell_hit[gi]),
                .rdata      (cell_rdata[gi])
            );

            for (gb = 0; gb < DATA_W; gb++)
            begin : g_col
                assign bit_col[gb][gi] = cell_rdata[gi][gb];
            end
        end

        // Cells that missed hold zero, so an OR of every cell gives the read word.
        for (gb = 0; gb < DATA_W; gb++)
        begin : g_or
            assign row_value[gb] = |bit_col[gb];
        end
    endgenerate

    assign row_hit = |cell_hit;

endmodule

@@ rtl/ple_ctrl.sv @@
// Sequencer: takes words, checks positions against the count, drives the row, emits results.
module ple_ctrl
    import ple_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ACT_W-1:0]         action,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    output cell_cmd_t                cmd,
    input  logic signed [DATA_W-1:0] row_value,
    input  logic                     row_hit,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     found,
    output logic [POS_W-1:0]         count,
    output logic                     empty_res
);

    localparam logic [CMP_W-1:0] DEPTH_W = CMP_W'(DEPTH);

    fsm_state_t               state_reg;
    fsm_state_t               state_next;
    logic [ACT_W-1:0]         act_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic [STAT_W-1:0]        res_stat_reg;
    logic [STAT_W-1:0]        res_stat_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [STAT_W-1:0]        status_reg;
    logic signed [DATA_W-1:0] read_value_reg;
    logic                     found_reg;
    logic [POS_W-1:0]         count_reg;
    logic                     empty_reg;
    logic                     load_out;
    logic                     take_in;
    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic                     full;

    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(cnt_reg);
    assign full    = (cnt_ext == DEPTH_W);
    assign take_in = in_valid && (state_reg == FSM_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        res_stat_next  = res_stat_reg;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = CELL_HOLD;
        cmd.pos        = pos_ext;
        cmd.cnt        = cnt_ext;
        cmd.value      = val_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC:
            begin
                res_stat_next = STAT_OK;
                cmd.op        = CELL_NOP;
                case (act_reg)
                    ACT_APPEND:
                    begin
                        if (full)
                        begin
                            res_stat_next = STAT_FULL;
                        end
                        else
                        begin
                            cmd.op   = CELL_APPEND;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    ACT_INSERT:
                    begin
                        // A bad position wins over a full list.
                        if (pos_ext > cnt_ext)
                        begin
                            res_stat_next = STAT_POS;
                        end
                        else if (full)
                        begin
                            res_stat_next = STAT_FULL;
                        end
                        else
                        begin
                            cmd.op   = CELL_INSERT;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                    ACT_READ:
                    begin
                        if (pos_ext >= cnt_ext)
                        begin
                            res_stat_next = STAT_POS;
                        end
                        else
                        begin
                            cmd.op = CELL_READ;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (pos_ext >= cnt_ext)
                        begin
                            res_stat_next = STAT_POS;
                        end
                        else
                        begin
                            cmd.op   = CELL_REMOVE;
                            cnt_next = cnt_reg - CNT_W'(1);
                        end
                    end
                    ACT_CONTAINS:
                    begin
                        cmd.op = CELL_MATCH;
                    end
                    ACT_CLEAR:
                    begin
                        cnt_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
                state_next = FSM_REDUCE;
            end
            FSM_REDUCE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_stat_reg <= res_stat_next;
        if (take_in)
        begin
            act_reg <= action;
            pos_reg <= position;
            val_reg <= value;
        end
        if (load_out)
        begin
            status_reg     <= res_stat_reg;
            read_value_reg <= row_value;
            found_reg      <= row_hit && (act_reg == ACT_CONTAINS);
            count_reg      <= cnt_ext[POS_W-1:0];
            empty_reg      <= (cnt_reg == '0);
        end
    end

    assign in_stall   = (state_reg != FSM_IDLE);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign found      = found_reg;
    assign count      = count_reg;
    assign empty_res  = empty_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_ext <= DEPTH_W)
        else $error("entry count above list depth");

    a_out_from_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == FSM_REDUCE))
        else $error("result raised outside the reduce step");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == STAT_FULL)) |-> (count_reg == DEPTH_W[POS_W-1:0]))
        else $error("full status with a list that is not full");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (status_reg == STAT_OK && !empty_reg))
        else $error("match reported on a failed action or an empty list");
`endif

endmodule

@@ tb/sv/positional_list_checker.sv @@
// Checker for the positional list engine: mirrors the list and compares every result word.
`timescale 1ns / 1ps

module positional_list_checker
    import ple_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [ACT_W-1:0]         action,
    input  logic [POS_W-1:0]         position,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [STAT_W-1:0]        status,
    input  logic signed [DATA_W-1:0] read_value,
    input  logic                     found,
    input  logic [POS_W-1:0]         count,
    input  logic                     empty_res,
    output int                       mismatches,
    output int                       replies_outstanding
);

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic [POS_W-1:0]         count;
        logic                     empty_res;
    } list_reply_t;

    logic signed [DATA_W-1:0] mirror_entries [DEPTH];
    int                       mirror_len = 0;
    list_reply_t              replies_due [$];

    function automatic list_reply_t apply_list_action(
        input logic [ACT_W-1:0]         act,
        input logic [POS_W-1:0]         pos,
        input logic signed [DATA_W-1:0] val
    );
        list_reply_t r;
        int          p;
        int          i;
        p            = int'(pos);
        r.status     = STAT_OK;
        r.read_value = '0;
        r.found      = 1'b0;
        case (act)
            ACT_APPEND:
            begin
                if (mirror_len >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    mirror_entries[mirror_len] = val;
                    mirror_len++;
                end
            end
            ACT_INSERT:
            begin
                // A bad position wins over a full list.
                if (p > mirror_len)
                    r.status = STAT_POS;
                else if (mirror_len >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    for (i = mirror_len; i > p; i--)
                        mirror_entries[i] = mirror_entries[i-1];
                    mirror_entries[p] = val;
                    mirror_len++;
                end
            end
            ACT_READ:
            begin
                if (p >= mirror_len)
                    r.status = STAT_POS;
                else
                    r.read_value = mirror_entries[p];
            end
            ACT_REMOVE:
            begin
                if (p >= mirror_len)
                    r.status = STAT_POS;
                else
                begin
                    for (i = p; i + 1 < mirror_len; i++)
                        mirror_entries[i] = mirror_entries[i+1];
                    mirror_len--;
                end
            end
            ACT_CONTAINS:
            begin
                for (i = 0; i < mirror_len; i++)
                    if (mirror_entries[i] == val)
                        r.found = 1'b1;
            end
            ACT_CLEAR:
            begin
                mirror_len = 0;
            end
            default:
            begin
            end
        endcase
        r.count     = mirror_len[POS_W-1:0];
        r.empty_res = (mirror_len == 0);
        return r;
    endfunction

    task automatic compare_field(
        input string             field_name,
        input logic [DATA_W-1:0] want,
        input logic [DATA_W-1:0] seen
    );
        if (seen !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field_name, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        list_reply_t due;
        if (!rst_n)
        begin
            mismatches = 0;
            replies_outstanding <= 0;
        end
        else
        begin
            // The result leaving at this edge always belongs to an older word.
            if (out_valid && !out_stall)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: result word with none expected, actual status %0d",
                             $time, status);
                    $display("    read_value 0x%0h found %0d count %0d empty %0d",
                             read_value, found, count, empty_res);
                    mismatches++;
                end
                else
                begin
                    due = replies_due.pop_front();
                    compare_field("status", DATA_W'(due.status), DATA_W'(status));
                    compare_field("read_value", due.read_value, read_value);
                    compare_field("found", DATA_W'(due.found), DATA_W'(found));
                    compare_field("count", DATA_W'(due.count), DATA_W'(count));
                    compare_field("empty_res", DATA_W'(due.empty_res),
                                  DATA_W'(empty_res));
                end
            end
            if (in_valid && !in_stall)
                replies_due.push_back(apply_list_action(action, position, value));
            replies_outstanding <= replies_due.size();
        end
    end

endmodule

@@ tb/sv/tb_positional_list_engine_top.sv @@
// Testbench top for the positional list engine: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module tb_positional_list_engine_top;
    import ple_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
    localparam int RANDOM_WORDS   = 650;
    localparam int QUIET_TAIL     = 90;
    localparam int WATCHDOG_LIMIT = 1000;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_stall;
    logic [ACT_W-1:0]         action     = ACT_APPEND;
    logic [POS_W-1:0]         position   = '0;
    logic signed [DATA_W-1:0] value      = '0;
    logic                     out_valid;
    logic                     out_stall  = 1'b0;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_value;
    logic                     found;
    logic [POS_W-1:0]         count;
    logic                     empty_res;

    int mismatches;
    int replies_outstanding;
    bit gaps_on     = 1'b1;
    int stall_left  = 0;
    int quiet_count = 0;
    int words_sent  = 0;
    int list_fill   = 0;
    logic signed [DATA_W-1:0] held_values [$];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    positional_list_engine_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .read_value (read_value),
        .found      (found),
        .count      (count),
        .empty_res  (empty_res)
    );

    positional_list_checker i_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .action              (action),
        .position            (position),
        .value               (value),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .status              (status),
        .read_value          (read_value),
        .found               (found),
        .count               (count),
        .empty_res           (empty_res),
        .mismatches          (mismatches),
        .replies_outstanding (replies_outstanding)
    );

    // Result side stalls in bursts of random length.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 17);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_count <= 0;
            else if (quiet_count + 1 >= WATCHDOG_LIMIT)
            begin
                $display("positional_list_engine_top test failed");
                $finish;
            end
            else
                quiet_count <= quiet_count + 1;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return '1;
            4, 5:
            begin
                if (held_values.size() > 0)
                    return held_values[$urandom_range(0, held_values.size() - 1)];
                return $urandom;
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(
        input logic [ACT_W-1:0]         act,
        input int                       pos,
        input logic signed [DATA_W-1:0] val
    );
        int p;
        p = int'(POS_W'(pos));
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        position <= POS_W'(pos);
        value    <= val;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
        // Track the length only to steer positions into or out of range.
        case (act)
            ACT_APPEND:
                if (list_fill < DEPTH)
                    list_fill++;
            ACT_INSERT:
                if (p <= list_fill && list_fill < DEPTH)
                    list_fill++;
            ACT_REMOVE:
                if (p < list_fill)
                    list_fill--;
            ACT_CLEAR:
                list_fill = 0;
            default:
            begin
            end
        endcase
        if (act == ACT_APPEND || act == ACT_INSERT)
        begin
            held_values.push_back(val);
            if (held_values.size() > 32)
                void'(held_values.pop_front());
        end
    endtask

    task automatic send_mixed_word();
        int  pick;
        bit  in_range;
        pick     = $urandom_range(0, 99);
        in_range = ($urandom_range(0, 99) < 85);
        if (pick < 22)
            send_word(ACT_APPEND, $urandom, pick_value());
        else if (pick < 40)
            send_word(ACT_INSERT,
                      in_range ? $urandom_range(0, list_fill)
                               : $urandom_range(list_fill + 1, 127),
                      pick_value());
        else if (pick < 72)
            send_word(pick < 58 ? ACT_READ : ACT_REMOVE,
                      (in_range && list_fill > 0) ? $urandom_range(0, list_fill - 1)
                                                  : $urandom_range(list_fill, 127),
                      pick_value());
        else if (pick < 86)
            send_word(ACT_CONTAINS, $urandom, pick_value());
        else if (pick < 89)
            send_word(ACT_CLEAR, $urandom, $urandom);
        else if (pick < 94)
            send_word(pick[0] ? ACT_SPARE_6 : ACT_SPARE_7, $urandom, $urandom);
        else
            send_word(pick[0] ? ACT_READ : ACT_REMOVE, $urandom_range(0, 127), $urandom);
    endtask

    // Holds the sender back until every result word has come out.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (replies_outstanding != 0);
    endtask

    initial
    begin
        int base;
        int kind;
        int n;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list, edge values, insert at the count, last-entry removal, spare codes.
        send_word(ACT_READ, 0, 32'd0);
        send_word(ACT_REMOVE, 0, 32'd0);
        send_word(ACT_CONTAINS, 0, 32'd0);
        send_word(ACT_CLEAR, 0, 32'd0);
        send_word(ACT_INSERT, 1, 32'h1234_5678);
        send_word(ACT_INSERT, 0, 32'h8000_0000);
        send_word(ACT_APPEND, 0, 32'h7FFF_FFFF);
        send_word(ACT_APPEND, 0, 32'hFFFF_FFFF);
        send_word(ACT_APPEND, 0, 32'h0000_0000);
        send_word(ACT_INSERT, 4, 32'h0000_0001);
        send_word(ACT_INSERT, 2, 32'h5555_5555);
        send_word(ACT_READ, 0, 32'd0);
        send_word(ACT_READ, 5, 32'd0);
        send_word(ACT_READ, 6, 32'd0);
        send_word(ACT_READ, 127, 32'hFFFF_FFFF);
        send_word(ACT_CONTAINS, 0, 32'h7FFF_FFFF);
        send_word(ACT_CONTAINS, 0, 32'hAAAA_AAAA);
        send_word(ACT_REMOVE, 5, 32'd0);
        send_word(ACT_CONTAINS, 0, 32'h0000_0001);
        send_word(ACT_REMOVE, 0, 32'd0);
        send_word(ACT_REMOVE, 127, 32'd0);
        send_word(ACT_INSERT, 127, 32'hFFFF_FFFF);
        send_word(ACT_SPARE_6, 127, 32'hFFFF_FFFF);
        send_word(ACT_SPARE_7, 42, 32'hAAAA_AAAA);
        send_word(ACT_CLEAR, 85, 32'h5555_5555);
        wait_for_drain();

        base = words_sent;
        kind = 5;
        while (words_sent - base < RANDOM_WORDS)
        begin
            if (words_sent - base >= RANDOM_WORDS - QUIET_TAIL)
                gaps_on <= 1'b0;
            else
                gaps_on <= ($urandom_range(0, 3) != 0);
            case (kind)
                5, 6:
                begin
                    // Fill to capacity, then probe the full list.
                    while (list_fill < DEPTH)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            send_word(ACT_APPEND, $urandom, pick_value());
                        else
                            send_word(ACT_INSERT, $urandom_range(0, list_fill), pick_value());
                    end
                    send_word(ACT_APPEND, $urandom, pick_value());
                    send_word(ACT_INSERT, list_fill, pick_value());
                    send_word(ACT_INSERT, $urandom_range(0, list_fill - 1), pick_value());
                    send_word(ACT_INSERT, $urandom_range(list_fill + 1, 127), pick_value());
                    send_word(ACT_READ, list_fill - 1, $urandom);
                    send_word(ACT_CONTAINS, $urandom, pick_value());
                    send_word(ACT_REMOVE, list_fill, $urandom);
                end
                7:
                begin
                    while (list_fill > 0)
                    begin
                        if ($urandom_range(0, 4) == 0)
                            send_word($urandom_range(0, 1) ? ACT_READ : ACT_CONTAINS,
                                      $urandom_range(0, list_fill - 1), pick_value());
                        else
                            send_word(ACT_REMOVE, $urandom_range(0, list_fill - 1), $urandom);
                    end
                    send_word(ACT_REMOVE, $urandom_range(0, 127), $urandom);
                    send_word(ACT_READ, 0, $urandom);
                end
                8:
                begin
                    send_word(ACT_CLEAR, $urandom, $urandom);
                    repeat (12) send_mixed_word();
                end
                9:
                begin
                    wait_for_drain();
                    repeat (8) send_mixed_word();
                end
                default:
                begin
                    n = $urandom_range(20, 50);
                    repeat (n) send_mixed_word();
                end
            endcase
            kind = $urandom_range(0, 9);
        end

        wait_for_drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("positional_list_engine_top test passed");
        else
            $display("positional_list_engine_top test failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ple_pkg.sv
rtl/ple_cell.sv
rtl/ple_row.sv
rtl/ple_ctrl.sv
rtl/positional_list_engine_top.sv
tb/sv/positional_list_checker.sv
tb/sv/tb_positional_list_engine_top.sv
